@@ rtl/cisp_pkg.sv @@
// cisp_pkg: shared types and codes of the cbor item stream parser
// event kinds, error codes, major types and the decoder interface structs
// no dependencies
`default_nettype none

package cisp_pkg;

    localparam int DATA_W  = 8;
    localparam int ARG_W   = 32;
    localparam int CNT_W   = 33;
    localparam int NEST_W  = 5;
    localparam int TDATA_W = 56;

    // event kinds
    localparam logic [1:0] EV_HEAD_BYTE = 2'd0;
    localparam logic [1:0] EV_HEAD_DONE = 2'd1;
    localparam logic [1:0] EV_PAYLOAD   = 2'd2;
    localparam logic [1:0] EV_ERROR     = 2'd3;

    // error codes
    localparam logic [1:0] ERR_AI    = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_DEEP  = 2'd2;

    // major types that need special handling
    localparam logic [2:0] MAJ_BSTR  = 3'd2;
    localparam logic [2:0] MAJ_TSTR  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;

    // additional info codes
    localparam logic [4:0] AI_ARG1 = 5'd24;
    localparam logic [4:0] AI_ARG2 = 5'd25;
    localparam logic [4:0] AI_ARG4 = 5'd26;

    // parser state seen by the byte decoder
    typedef struct packed {
        logic              err_latched;
        logic              level_full;
        logic [2:0]        head_left;
        logic [2:0]        major;
        logic [ARG_W-1:0]  acc;
        logic [ARG_W-1:0]  payload_left;
    } cisp_state_t;

    // per-byte decode result
    typedef struct packed {
        logic [1:0]        kind;
        logic [ARG_W-1:0]  arg;
        logic [DATA_W-1:0] pbyte;
        logic [2:0]        head_left;
        logic [ARG_W-1:0]  acc;
        logic [2:0]        major;
        logic [ARG_W-1:0]  payload_left;
        logic              err_set;
        logic [1:0]        err_code;
        logic              finish;
        logic              push;
        logic [CNT_W-1:0]  push_cnt;
    } cisp_dec_t;

endpackage

`default_nettype wire

@@ rtl/cisp_stack.sv @@
// cisp_stack: container count stack memory, one write and one read port
// read data is registered; no dependencies
`default_nettype none

module cisp_stack #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 33,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/cisp_decode.sv @@
// cisp_decode: per-byte decode of heads, arguments and string payload
// depends on cisp_pkg
`default_nettype none

module cisp_decode
    import cisp_pkg::*;
(
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire cisp_state_t       st,
    output cisp_dec_t              dec
);

    always_comb begin
        logic [4:0]       ai;
        logic             hc;
        logic [ARG_W-1:0] hc_arg;
        logic [CNT_W-1:0] cnt;

        ai     = data_byte[4:0];
        hc     = 1'b0;
        hc_arg = '0;
        cnt    = '0;

        dec              = '0;
        dec.kind         = EV_HEAD_BYTE;
        dec.arg          = st.acc;
        dec.head_left    = st.head_left;
        dec.acc          = st.acc;
        dec.major        = st.major;
        dec.payload_left = st.payload_left;
        dec.err_code     = ERR_AI;

        if (st.err_latched) begin
            dec.kind = EV_ERROR;
        end else if (st.payload_left != '0) begin
            dec.payload_left = st.payload_left - ARG_W'(1);
            dec.kind         = EV_PAYLOAD;
            dec.pbyte        = data_byte;
            dec.arg          = dec.payload_left;
            dec.finish       = (dec.payload_left == '0);
        end else if (st.head_left != 3'd0) begin
            // big-endian argument byte
            dec.acc       = {st.acc[ARG_W-DATA_W-1:0], data_byte};
            dec.head_left = st.head_left - 3'd1;
            dec.arg       = dec.acc;
            if (dec.head_left == 3'd0) begin
                hc     = 1'b1;
                hc_arg = dec.acc;
            end
        end else begin
            // initial byte of a head
            dec.major = data_byte[7:5];
            dec.acc   = '0;
            dec.arg   = '0;
            if (ai < AI_ARG1) begin
                dec.acc = ARG_W'(ai);
                dec.arg = ARG_W'(ai);
                hc      = 1'b1;
                hc_arg  = ARG_W'(ai);
            end else begin
                case (ai)
                    AI_ARG1: dec.head_left = 3'd1;
                    AI_ARG2: dec.head_left = 3'd2;
                    AI_ARG4: dec.head_left = 3'd4;
                    default: begin
                        dec.err_set  = 1'b1;
                        dec.err_code = ERR_AI;
                        dec.kind     = EV_ERROR;
                    end
                endcase
            end
        end

        if (hc) begin
            dec.kind = EV_HEAD_DONE;
            case (dec.major) inside
                MAJ_BSTR, MAJ_TSTR: begin
                    dec.payload_left = hc_arg;
                    dec.finish       = (hc_arg == '0);
                end
                MAJ_ARRAY, MAJ_MAP: begin
                    // a map counts key and value
                    cnt = (dec.major == MAJ_MAP) ? {hc_arg, 1'b0} : {1'b0, hc_arg};
                    if (cnt == '0) begin
                        dec.finish = 1'b1;
                    end else if (st.level_full) begin
                        dec.err_set  = 1'b1;
                        dec.err_code = ERR_DEEP;
                        dec.kind     = EV_ERROR;
                    end else begin
                        dec.push     = 1'b1;
                        dec.push_cnt = cnt;
                    end
                end
                default: dec.finish = 1'b1;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/cbor_item_stream_parser.sv @@
// cbor_item_stream_parser: top level, byte sequencer, stack control, output register
// depends on cisp_pkg, cisp_decode and cisp_stack
//
// The parser takes one encoded byte per input transaction and returns exactly
// one result transaction for it. For a byte that does not finish an item inside
// an open array or map, the result is registered when the byte is accepted.
// When an item finishes while levels are open, the remaining-count stack (a
// synchronous memory of MAX_DEPTH entries) is walked upward, each visited level
// taking a memory read and then a decrement and write-back; the walk stops at
// the first level whose count stays nonzero or after the outermost one closes.
// The stack needs no clearing pass after reset; only entries below the current
// depth are ever used. A result waits in an output register, and the next byte
// is taken in the same cycle as that result leaves. The end-of-buffer byte
// (s_tlast) returns all state to reset.
`default_nettype none

module cbor_item_stream_parser
    import cisp_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input byte stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic               s_tlast,   // end_of_buffer
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [2:0] major_type, [34:3] argument,
                                               // [42:35] payload_byte, [44:43] error_code,
                                               // [49:45] nest_level, [55:50] zero
    output logic [1:0]              m_tuser,   // event_kind
    output logic                    m_tlast    // item_done
);

    localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a byte
    localparam logic [1:0] ST_RD   = 2'd1;   // stack top read in flight
    localparam logic [1:0] ST_UPD  = 2'd2;   // decrement and write back the top

    // parser state
    logic [1:0]        state_reg,        state_next;
    logic [2:0]        head_left_reg,    head_left_next;
    logic [ARG_W-1:0]  acc_reg,          acc_next;
    logic [2:0]        major_reg,        major_next;
    logic [ARG_W-1:0]  payload_left_reg, payload_left_next;
    logic [LVL_W-1:0]  level_reg,        level_next;
    logic              err_reg,          err_next;
    logic [1:0]        code_reg,         code_next;

    // result of the byte held while the stack is walked
    logic [1:0]        pend_kind_reg,    pend_kind_next;
    logic [ARG_W-1:0]  pend_arg_reg,     pend_arg_next;
    logic [DATA_W-1:0] pend_pbyte_reg,   pend_pbyte_next;
    logic              pend_last_reg,    pend_last_next;

    // output register
    logic               m_valid_reg,     m_valid_next;
    logic [TDATA_W-1:0] m_data_reg,      m_data_next;
    logic [1:0]         m_kind_reg,      m_kind_next;
    logic               m_done_reg,      m_done_next;

    logic              accept;
    logic              level_full;
    logic [LVL_W-1:0]  level_m1;
    cisp_state_t       dec_st;
    cisp_dec_t         dec;

    // stack memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic [CNT_W-1:0]  mem_rdata;
    logic [CNT_W-1:0]  top_left;
    logic              top_zero;

    // finalize path, shared by the accept cycle and the last stack update
    logic              fin_en;
    logic [1:0]        fin_kind;
    logic [ARG_W-1:0]  fin_arg;
    logic [DATA_W-1:0] fin_pbyte;
    logic              fin_done;
    logic              fin_last;
    logic              cascade;
    logic [LVL_W-1:0]  post_level;
    logic              post_err;
    logic [1:0]        post_code;
    logic              post_busy;
    logic [ARG_W-1:0]  post_acc;
    logic [2:0]        post_major;
    logic              trunc;
    logic [1:0]        out_kind;
    logic [1:0]        out_code;
    logic [ARG_W-1:0]  out_arg;
    logic [DATA_W-1:0] out_pbyte;
    logic              out_done;
    logic [NEST_W-1:0] out_nest;

    assign s_tready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign level_full = (level_reg >= LVL_W'(MAX_DEPTH));
    assign level_m1   = level_reg - LVL_W'(1);

    assign dec_st.err_latched  = err_reg;
    assign dec_st.level_full   = level_full;
    assign dec_st.head_left    = head_left_reg;
    assign dec_st.major        = major_reg;
    assign dec_st.acc          = acc_reg;
    assign dec_st.payload_left = payload_left_reg;

    cisp_decode u_decode (
        .data_byte (s_tdata),
        .st        (dec_st),
        .dec       (dec)
    );

    // the top entry is always addressed; it is read in ST_RD and used in ST_UPD
    assign top_left = mem_rdata - CNT_W'(1);
    assign top_zero = (top_left == '0);

    assign mem_we    = (accept && dec.push) || (state_reg == ST_UPD);
    assign mem_waddr = (state_reg == ST_UPD) ? level_m1[ADDR_W-1:0] : level_reg[ADDR_W-1:0];
    assign mem_wdata = (state_reg == ST_UPD) ? top_left : dec.push_cnt;

    cisp_stack #(
        .DEPTH  (MAX_DEPTH),
        .WIDTH  (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (level_m1[ADDR_W-1:0]),
        .rd_data (mem_rdata)
    );

    // finalize sources
    always_comb begin
        cascade = 1'b0;
        if (state_reg == ST_UPD) begin
            // walking the stack: state other than the level was settled at accept
            post_level = top_zero ? level_m1 : level_reg;
            post_err   = err_reg;
            post_code  = code_reg;
            post_busy  = (head_left_reg != 3'd0) || (payload_left_reg != '0);
            post_acc   = acc_reg;
            post_major = major_reg;
            fin_en     = !top_zero || (level_reg == LVL_W'(1));
            fin_kind   = pend_kind_reg;
            fin_arg    = pend_arg_reg;
            fin_pbyte  = pend_pbyte_reg;
            fin_done   = top_zero;
            fin_last   = pend_last_reg;
        end else begin
            cascade    = dec.finish && (level_reg != '0);
            post_level = level_reg + LVL_W'(dec.push);
            post_err   = err_reg || dec.err_set;
            post_code  = dec.err_set ? dec.err_code : code_reg;
            post_busy  = (dec.head_left != 3'd0) || (dec.payload_left != '0);
            post_acc   = dec.acc;
            post_major = dec.major;
            fin_en     = accept && !cascade;
            fin_kind   = dec.kind;
            fin_arg    = dec.arg;
            fin_pbyte  = dec.pbyte;
            fin_done   = dec.finish;
            fin_last   = s_tlast;
        end

        // unfinished head, payload or container at the end of the buffer
        trunc = fin_last && !post_err && (post_busy || (post_level != '0));

        out_kind  = trunc ? EV_ERROR : fin_kind;
        out_arg   = fin_arg;
        out_pbyte = fin_pbyte;
        out_done  = fin_done;
        out_code  = 2'd0;
        if (out_kind == EV_ERROR) begin
            out_arg   = post_acc;
            out_pbyte = '0;
            out_done  = 1'b0;
            out_code  = trunc ? ERR_TRUNC : post_code;
        end
        out_nest = NEST_W'({{NEST_W{1'b0}}, post_level});
    end

    // next state
    always_comb begin
        state_next        = state_reg;
        head_left_next    = head_left_reg;
        acc_next          = acc_reg;
        major_next        = major_reg;
        payload_left_next = payload_left_reg;
        level_next        = level_reg;
        err_next          = err_reg;
        code_next         = code_reg;
        pend_kind_next    = pend_kind_reg;
        pend_arg_next     = pend_arg_reg;
        pend_pbyte_next   = pend_pbyte_reg;
        pend_last_next    = pend_last_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_data_next       = m_data_reg;
        m_kind_next       = m_kind_reg;
        m_done_next       = m_done_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    head_left_next    = dec.head_left;
                    acc_next          = dec.acc;
                    major_next        = dec.major;
                    payload_left_next = dec.payload_left;
                    level_next        = post_level;
                    err_next          = post_err;
                    code_next         = post_code;
                    pend_kind_next    = dec.kind;
                    pend_arg_next     = dec.arg;
                    pend_pbyte_next   = dec.pbyte;
                    pend_last_next    = s_tlast;
                    if (cascade) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                level_next = post_level;
                state_next = fin_en ? ST_IDLE : ST_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin_en) begin
            m_valid_next = 1'b1;
            m_kind_next  = out_kind;
            m_done_next  = out_done;
            m_data_next  = {6'd0, out_nest, out_code, out_pbyte, out_arg, post_major};
            if (trunc) begin
                err_next  = 1'b1;
                code_next = ERR_TRUNC;
            end
            // end of buffer: back to the initial state
            if (fin_last) begin
                head_left_next    = 3'd0;
                acc_next          = '0;
                major_next        = 3'd0;
                payload_left_next = '0;
                level_next        = '0;
                err_next          = 1'b0;
                code_next         = ERR_AI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            head_left_reg    <= 3'd0;
            acc_reg          <= '0;
            major_reg        <= 3'd0;
            payload_left_reg <= '0;
            level_reg        <= '0;
            err_reg          <= 1'b0;
            code_reg         <= ERR_AI;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            head_left_reg    <= head_left_next;
            acc_reg          <= acc_next;
            major_reg        <= major_next;
            payload_left_reg <= payload_left_next;
            level_reg        <= level_next;
            err_reg          <= err_next;
            code_reg         <= code_next;
            m_valid_reg      <= m_valid_next;
        end
        pend_kind_reg  <= pend_kind_next;
        pend_arg_reg   <= pend_arg_next;
        pend_pbyte_reg <= pend_pbyte_next;
        pend_last_reg  <= pend_last_next;
        m_data_reg     <= m_data_next;
        m_kind_reg     <= m_kind_next;
        m_done_reg     <= m_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_done_reg;

    // depth never passes the stack size
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(MAX_DEPTH))
        else $error("stack level beyond depth");

    // the stack is only walked with an open level
    a_walk_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (level_reg != '0))
        else $error("stack update with no open level");

    // output slot stays free while a result is pending
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("output loaded during stack walk");

    // no push into a full stack
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dec.push) |-> !level_full)
        else $error("push into full stack");

    // a read is always followed by its update
    a_read_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |=> (state_reg == ST_UPD))
        else $error("stack read not followed by update");

endmodule

`default_nettype wire
